// ----- hdl/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared constants, frame type and the glitch filter used by the status frame
// parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int FRAME_LEN = 14;
  localparam int HDR_LEN   = 4;
  localparam int CNT_W     = $clog2(FRAME_LEN);
  localparam int DROP_W    = $clog2(HDR_LEN + 1);

  localparam logic [HDR_LEN-1:0][7:0] HDR_PATTERN = {8'h00, 8'h01, 8'h01, 8'h23};

  localparam logic signed [17:0] TEMP_OFFSET = 18'sd300;

  localparam logic signed [17:0] VOLT_UNSET = -18'sd10;
  localparam logic signed [17:0] VOLT_FIRST = 18'sd650;
  localparam logic signed [17:0] VOLT_STEP  = 18'sd50;
  localparam logic signed [17:0] AMP_UNSET  = -18'sd10;
  localparam logic signed [17:0] AMP_FIRST  = 18'sd250;
  localparam logic signed [17:0] AMP_STEP   = 18'sd250;
  localparam logic signed [17:0] ACV_UNSET  = 18'sd0;
  localparam logic signed [17:0] ACV_FIRST  = 18'sd300;
  localparam logic signed [17:0] ACV_STEP   = 18'sd50;
  localparam logic signed [17:0] FREQ_UNSET = -18'sd2;
  localparam logic signed [17:0] FREQ_FIRST = 18'sd200;
  localparam logic signed [17:0] FREQ_STEP  = 18'sd20;
  localparam logic signed [17:0] TEMP_UNSET = -18'sd10;
  localparam logic signed [17:0] TEMP_FIRST = 18'sd1000;
  localparam logic signed [17:0] TEMP_STEP  = 18'sd100;

  typedef struct packed {
    logic [7:0]  mode;
    logic [15:0] volt;
    logic [15:0] amp;
    logic [15:0] acv;
    logic [7:0]  freq;
    logic [15:0] temp;
  } frame_t;

  function automatic logic signed [17:0] sfp_filt(
    input logic signed [17:0] cur,
    input logic signed [17:0] v,
    input logic signed [17:0] unset,
    input logic signed [17:0] first_max,
    input logic signed [17:0] step
  );
    logic signed [17:0] d;
    d = cur - v;
    if ((cur == unset && v < first_max) || (d > -step && d < step)) begin
      return v;
    end
    return cur;
  endfunction

endpackage

// ----- hdl/sfp_window.sv -----
// ----------------------------------------------------------------------------
// sfp_window
// Byte window with header check; drops leading bytes on a header mismatch
// and reports a complete frame on a match.
// ----------------------------------------------------------------------------
module sfp_window (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     rx_byte,
  output logic           hit,
  output sfp_pkg::frame_t frame
);
  import sfp_pkg::*;

  logic [7:0]       win [FRAME_LEN];
  logic [CNT_W-1:0] cnt;

  logic [7:0]        full_win  [FRAME_LEN];
  logic [7:0]        shift_win [FRAME_LEN];
  logic [HDR_LEN-1:0] diff;
  logic [DROP_W-1:0]  drop;
  logic               is_last;

  always_comb begin
    for (int k = 0; k < FRAME_LEN - 1; k++) begin
      full_win[k] = win[k];
    end
    full_win[FRAME_LEN-1] = rx_byte;
  end

  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      diff[i] = (full_win[i] != HDR_PATTERN[i]);
    end
    drop = '0;
    for (int i = HDR_LEN - 1; i >= 0; i--) begin
      if (diff[i]) begin
        drop = DROP_W'(i + 1);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < FRAME_LEN; k++) begin
      shift_win[k] = full_win[k];
      for (int d = 1; d <= HDR_LEN; d++) begin
        if (k + d < FRAME_LEN) begin
          if (drop == DROP_W'(d)) begin
            shift_win[k] = full_win[k + d];
          end
        end
      end
    end
  end

  assign is_last = (cnt == CNT_W'(FRAME_LEN - 1));
  assign hit     = fire && is_last && (diff == '0);

  assign frame.mode = full_win[4];
  assign frame.volt = {full_win[5], full_win[6]};
  assign frame.amp  = {full_win[7], full_win[8]};
  assign frame.acv  = {full_win[9], full_win[10]};
  assign frame.freq = full_win[11];
  assign frame.temp = {full_win[12], full_win[13]};

  always_ff @(posedge clk) begin
    if (fire) begin
      if (!is_last) begin
        win[cnt] <= rx_byte;
      end else if (diff != '0) begin
        for (int k = 0; k < FRAME_LEN; k++) begin
          win[k] <= shift_win[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (fire) begin
      if (!is_last) begin
        cnt <= cnt + CNT_W'(1);
      end else if (diff != '0) begin
        cnt <= CNT_W'(FRAME_LEN) - CNT_W'(drop);
      end else begin
        cnt <= '0;
      end
    end
  end

endmodule

// ----- hdl/sfp_filter.sv -----
// ----------------------------------------------------------------------------
// sfp_filter
// Glitch filter and stored measurement registers; the stored values are the
// result payload.
// ----------------------------------------------------------------------------
module sfp_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               hit,
  input  sfp_pkg::frame_t    frame,
  output logic [7:0]         op_mode,
  output logic signed [16:0] dc_volt_tenths,
  output logic signed [16:0] dc_amp_tenths,
  output logic [15:0]        ac_volts,
  output logic signed [8:0]  ac_freq_halves,
  output logic signed [16:0] temp_tenths
);
  import sfp_pkg::*;

  logic signed [17:0] volt_next;
  logic signed [17:0] amp_next;
  logic signed [17:0] acv_next;
  logic signed [17:0] freq_next;
  logic signed [17:0] temp_next;
  logic signed [17:0] temp_val;

  assign temp_val = $signed({2'b00, frame.temp}) - TEMP_OFFSET;

  assign volt_next = sfp_filt({dc_volt_tenths[16], dc_volt_tenths},
                              $signed({2'b00, frame.volt}),
                              VOLT_UNSET, VOLT_FIRST, VOLT_STEP);
  assign amp_next  = sfp_filt({dc_amp_tenths[16], dc_amp_tenths},
                              $signed({2'b00, frame.amp}),
                              AMP_UNSET, AMP_FIRST, AMP_STEP);
  assign acv_next  = sfp_filt($signed({2'b00, ac_volts}),
                              $signed({2'b00, frame.acv}),
                              ACV_UNSET, ACV_FIRST, ACV_STEP);
  assign freq_next = sfp_filt({{9{ac_freq_halves[8]}}, ac_freq_halves},
                              $signed({10'b0, frame.freq}),
                              FREQ_UNSET, FREQ_FIRST, FREQ_STEP);
  assign temp_next = sfp_filt({temp_tenths[16], temp_tenths}, temp_val,
                              TEMP_UNSET, TEMP_FIRST, TEMP_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode        <= '0;
      dc_volt_tenths <= VOLT_UNSET[16:0];
      dc_amp_tenths  <= AMP_UNSET[16:0];
      ac_volts       <= ACV_UNSET[15:0];
      ac_freq_halves <= FREQ_UNSET[8:0];
      temp_tenths    <= TEMP_UNSET[16:0];
    end else if (hit) begin
      op_mode        <= frame.mode;
      dc_volt_tenths <= volt_next[16:0];
      dc_amp_tenths  <= amp_next[16:0];
      ac_volts       <= acv_next[15:0];
      ac_freq_halves <= freq_next[8:0];
      temp_tenths    <= temp_next[16:0];
    end
  end

endmodule

// ----- hdl/status_frame_parser_with_glitch_filter.sv -----
// ----------------------------------------------------------------------------
// status_frame_parser_with_glitch_filter
// Status frame parser with per-measurement glitch filter.
//
// Input channel (in_valid / in_stall / rx_byte) takes one received serial
// byte per transaction. Bytes collect in a 14-byte window; a full window
// with header 23 01 01 00 yields one result, a mismatch drops leading bytes.
// Output channel (out_valid / out_stall) carries the six stored values after
// each matched frame.
// A result passes the input register, then the window and filter logic
// into the result register. Throughput: one byte per cycle while no result
// is held under out_stall, set by the single input register feeding the
// window and filter logic; the result register is the stored values.
// In_stall rises only while a result is held under out_stall and a byte is
// waiting in the input register; held results do not change.
// Reset empties the window and sets all stored values to their unset marks;
// the block takes bytes in the cycle after reset.
// ----------------------------------------------------------------------------
module status_frame_parser_with_glitch_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         op_mode,
  output logic signed [16:0] dc_volt_tenths,
  output logic signed [16:0] dc_amp_tenths,
  output logic [15:0]        ac_volts,
  output logic signed [8:0]  ac_freq_halves,
  output logic signed [16:0] temp_tenths
);
  import sfp_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;
  logic       fire;
  logic       hit;
  frame_t     frame;

  assign advance  = !out_valid || !out_stall;
  assign fire     = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hit;
    end
  end

  sfp_window u_window (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (hold_byte),
    .hit     (hit),
    .frame   (frame)
  );

  sfp_filter u_filter (
    .clk            (clk),
    .rst            (rst),
    .hit            (hit),
    .frame          (frame),
    .op_mode        (op_mode),
    .dc_volt_tenths (dc_volt_tenths),
    .dc_amp_tenths  (dc_amp_tenths),
    .ac_volts       (ac_volts),
    .ac_freq_halves (ac_freq_halves),
    .temp_tenths    (temp_tenths)
  );

endmodule

// ----- hdl/sfp_checker.sv -----
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks for the status frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [16:0] dc_volt_tenths,
  input logic signed [16:0] dc_amp_tenths,
  input logic signed [8:0]  ac_freq_halves,
  input logic signed [16:0] temp_tenths
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result transaction shown right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side is free");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(temp_tenths)
      && $stable(dc_volt_tenths)))
    else $error("stalled result transaction changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temp_tenths >= -17'sd300 && ac_freq_halves >= -9'sd2
      && dc_volt_tenths >= -17'sd10 && dc_amp_tenths >= -17'sd10))
    else $error("stored measurement below its lowest value");

endmodule

bind status_frame_parser_with_glitch_filter sfp_checker u_sfp_checker (.*);
